### rtl/bffa_pkg.sv
// Shared types and constants of the bitmap first-fit allocator.
package bffa_pkg;

    localparam int CFG_W    = 14;
    localparam int NUM_W    = 14;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 2'd0,
        ST_NO_FREE      = 2'd1,
        ST_OUT_OF_RANGE = 2'd2,
        ST_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_FDIV  = 7'b0001000,
        S_FADDR = 7'b0010000,
        S_FCHK  = 7'b0100000,
        S_RESP  = 7'b1000000
    } state_t;

endpackage

### rtl/bitmap_first_fit_allocator_core.sv
// Bitmap first-fit allocator: usage bitmap in one synchronous memory, one item at a time.
//
// The block hands out and takes back numbered entries (1 to the configured limit, which is
// entries_in_use clamped to ENTRIES). Usage bits live in one WORD_BITS-wide memory with a
// registered read port. An allocate item scans the words one per cycle from the bottom, a
// pace set by that single read port; a free item goes through entry-to-word mapping, read,
// check and write back. Each item gives exactly one result, held in an output register so
// the next item can be taken while it waits. After reset a clearing pass writes every word
// to zero, during which in_stall stays high; configuration writes are taken at any time.
module bitmap_first_fit_allocator_core #(
    parameter int ENTRIES   = 8192,
    parameter int WORD_BITS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bffa_pkg::CFG_W-1:0]     entries_in_use,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           operation,
    input  logic [bffa_pkg::NUM_W-1:0]     entry_number,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [bffa_pkg::STATUS_W-1:0]  status,
    output logic [bffa_pkg::NUM_W-1:0]     allocated_number,
    output logic [bffa_pkg::NUM_W-1:0]     free_count
);

    import bffa_pkg::*;

    localparam int NUM_WORDS = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int CW        = $clog2(ENTRIES + WORD_BITS);
    localparam int LW        = (CW > CFG_W) ? CW : CFG_W;
    localparam int DIV_SH    = NUM_W + BIT_W;
    localparam int DIV_M     = (2 ** DIV_SH + WORD_BITS - 1) / WORD_BITS;
    localparam int M_W       = $clog2(DIV_M + 1);
    localparam int P_W       = NUM_W + M_W;

    logic [WORD_BITS-1:0] bitmap_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;

    state_t               state_reg, state_next;
    logic [WADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [WADDR_W-1:0]   issue_addr_reg, issue_addr_next;
    logic [CW-1:0]        issue_base_reg, issue_base_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [WADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [CW-1:0]        pend_base_reg, pend_base_next;
    logic [CFG_W-1:0]     limit_cfg_reg, limit_cfg_next;
    logic [NUM_W-1:0]     count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;

    logic [NUM_W-1:0]     num_reg, num_next;
    logic [WADDR_W-1:0]   q_reg, q_next;
    logic [BIT_W-1:0]     bit_reg, bit_next;
    status_t              res_status_reg, res_status_next;
    logic [NUM_W-1:0]     res_number_reg, res_number_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [NUM_W-1:0]     number_reg, number_next;
    logic [NUM_W-1:0]     free_reg, free_next;

    logic                 mem_we;
    logic [WADDR_W-1:0]   mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WADDR_W-1:0]   mem_raddr;

    logic [LW-1:0]        cfg_wide;
    logic [LW-1:0]        lim_wide;
    logic [CW-1:0]        lim;
    logic [CW-1:0]        rem;
    logic [WORD_BITS-1:0] use_mask;
    logic [WORD_BITS-1:0] cand;
    logic [WORD_BITS-1:0] low_one;
    logic [BIT_W-1:0]     low_idx;
    logic [CW-1:0]        granted;
    logic [NUM_W-1:0]     x_val;
    logic [P_W-1:0]       prod;
    logic [P_W-1:0]       q_full;
    logic [NUM_W-1:0]     word_start;
    logic [NUM_W-1:0]     bit_off;
    logic [WORD_BITS-1:0] bit_sel;
    logic                 in_take;
    logic                 out_take;
    logic                 resp_load;

    assign cfg_ready        = 1'b1;
    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign allocated_number = number_reg;
    assign free_count       = free_reg;

    assign in_take  = in_valid && (state_reg == S_IDLE);
    assign out_take = out_valid_reg && !out_stall;

    assign cfg_wide = LW'(limit_cfg_reg);
    assign lim_wide = (cfg_wide > LW'(ENTRIES)) ? LW'(ENTRIES) : cfg_wide;
    assign lim      = CW'(lim_wide);
    assign rem      = lim - pend_base_reg;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            use_mask[j] = (CW'(j) < rem);
        end
    end

    assign cand    = ~rd_data_reg & use_mask;
    assign low_one = cand & (~cand + WORD_BITS'(1));

    always_comb
    begin
        low_idx = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            low_idx = low_idx | (low_one[j] ? BIT_W'(j) : BIT_W'(0));
        end
    end

    assign granted    = pend_base_reg + CW'(low_idx) + CW'(1);
    assign x_val      = num_reg - NUM_W'(1);
    assign prod       = P_W'(x_val) * P_W'(DIV_M);
    assign q_full     = prod >> DIV_SH;
    assign word_start = NUM_W'(q_reg) * NUM_W'(WORD_BITS);
    assign bit_off    = x_val - word_start;
    assign bit_sel    = WORD_BITS'(1) << bit_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        issue_addr_next = issue_addr_reg;
        issue_base_next = issue_base_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_base_next  = pend_base_reg;
        limit_cfg_next  = limit_cfg_reg;
        count_next      = count_reg;
        num_next        = num_reg;
        q_next          = q_reg;
        bit_next        = bit_reg;
        res_status_next = res_status_reg;
        res_number_next = res_number_reg;
        resp_load       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = rd_data_reg;
        mem_re          = 1'b0;
        mem_raddr       = issue_addr_reg;

        if (cfg_valid)
        begin
            limit_cfg_next = entries_in_use;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + WADDR_W'(1);
                if (clr_addr_reg == WADDR_W'(NUM_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_take)
                begin
                    num_next        = entry_number;
                    issue_addr_next = '0;
                    issue_base_next = '0;
                    if (op_t'(operation) == OP_ALLOC)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FDIV;
                    end
                end
            end
            S_SCAN:
            begin
                if (pend_valid_reg && (cand != '0))
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = pend_addr_reg;
                    mem_wdata       = rd_data_reg | low_one;
                    count_next      = count_reg + NUM_W'(1);
                    res_status_next = ST_OK;
                    res_number_next = NUM_W'(granted);
                    state_next      = S_RESP;
                end
                else if (issue_base_reg >= lim)
                begin
                    res_status_next = ST_NO_FREE;
                    res_number_next = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = issue_addr_reg;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = issue_addr_reg;
                    pend_base_next  = issue_base_reg;
                    issue_addr_next = issue_addr_reg + WADDR_W'(1);
                    issue_base_next = issue_base_reg + CW'(WORD_BITS);
                end
            end
            S_FDIV:
            begin
                res_number_next = '0;
                if ((num_reg == '0) || (LW'(num_reg) > lim_wide))
                begin
                    res_status_next = ST_OUT_OF_RANGE;
                    state_next      = S_RESP;
                end
                else
                begin
                    q_next     = WADDR_W'(q_full);
                    state_next = S_FADDR;
                end
            end
            S_FADDR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = q_reg;
                bit_next   = BIT_W'(bit_off);
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if ((rd_data_reg & bit_sel) == '0)
                begin
                    res_status_next = ST_ALREADY_FREE;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = q_reg;
                    mem_wdata       = rd_data_reg & ~bit_sel;
                    res_status_next = ST_OK;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - NUM_W'(1);
                    end
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    resp_load  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        number_next    = number_reg;
        free_next      = free_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        if (resp_load)
        begin
            out_valid_next = 1'b1;
            status_next    = res_status_reg;
            number_next    = res_number_reg;
            free_next      = (lim_wide > LW'(count_reg)) ?
                             NUM_W'(lim_wide - LW'(count_reg)) : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= bitmap_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            issue_addr_reg <= '0;
            issue_base_reg <= '0;
            pend_valid_reg <= 1'b0;
            limit_cfg_reg  <= CFG_W'(8192);
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            issue_addr_reg <= issue_addr_next;
            issue_base_reg <= issue_base_next;
            pend_valid_reg <= pend_valid_next;
            limit_cfg_reg  <= limit_cfg_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg  <= pend_addr_next;
        pend_base_reg  <= pend_base_next;
        num_reg        <= num_next;
        q_reg          <= q_next;
        bit_reg        <= bit_next;
        res_status_reg <= res_status_next;
        res_number_reg <= res_number_next;
        status_reg     <= status_next;
        number_reg     <= number_next;
        free_reg       <= free_next;
    end

endmodule
